@@ hdl/stq_pkg.sv @@
// Package for the sorted timer queue: word types, codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
package stq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = 4;
    localparam int CNT_W      = 5;
    localparam int TIME_W     = 64;

    localparam logic [1:0] FUNC_ARM    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_MISUSE  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] time_value;
    } t_in_word;

    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   expired_id;
        logic [1:0]        status;
        logic [TIME_W-1:0] next_deadline;
        logic              last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EXP_CHECK,
        S_EXP_SHIFT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;       // capture input word
        logic do_arm;     // insert into order list
        logic do_cancel;  // remove from order list
        logic pop_head;   // fire and remove head
    } t_cmd;

    typedef struct packed {
        logic head_due;   // list nonempty and head deadline <= time
        logic arm_ok;
        logic cancel_ok;
        logic [1:0] func;
    } t_stat;

endpackage

@@ hdl/stq_datapath.sv @@
// Datapath of the sorted timer queue: deadline store, sorted cell chain of
// slot ids, pending marks and earliest deadline. Uses stq_pkg.
module stq_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stq_pkg::t_in_word i_word,
    input  logic [63:0]       i_prio_threshold,
    input  stq_pkg::t_cmd     i_cmd,
    output stq_pkg::t_stat    o_stat,
    output logic [3:0]        o_head_id,
    output logic [63:0]       o_earliest,
    output logic [63:0]       o_next_dl
);
    import stq_pkg::*;

    t_in_word                r_word;
    logic [TIME_W-1:0]       r_dl    [NUM_TIMERS];
    logic [ID_W-1:0]         r_ord   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   r_pend;
    logic [CNT_W-1:0]        r_cnt;
    logic [NUM_TIMERS-1:0]   w_ge;     // cell deadline places new one before it
    logic [NUM_TIMERS-1:0]   w_hit;    // cell holds cancelled id
    logic [NUM_TIMERS-1:0]   w_late;   // cell deadline is past the word's time
    logic [NUM_TIMERS-1:0]   w_valid;
    logic [NUM_TIMERS-1:0]   w_ins_before;
    logic [NUM_TIMERS-1:0]   w_rm_before;
    logic                    w_after;
    logic [TIME_W-1:0]       w_head_dl;
    logic [TIME_W-1:0]       w_next_dl;

    assign w_after   = r_word.time_value > i_prio_threshold;
    assign w_head_dl = r_dl[r_ord[0]];

    always_comb begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
            w_valid[k] = CNT_W'(k) < r_cnt;
            w_ge[k]  = w_valid[k] && (w_after ? (r_dl[r_ord[k]] > r_word.time_value)
                                              : (r_dl[r_ord[k]] >= r_word.time_value));
            w_hit[k] = w_valid[k] && (r_ord[k] == r_word.timer_id);
            w_late[k] = w_valid[k] && (r_dl[r_ord[k]] > r_word.time_value);
        end
        // insert position: first cell with w_ge set, or end of list
        w_ins_before[0] = 1'b0;
        w_rm_before[0]  = 1'b0;
        for (int k = 1; k < NUM_TIMERS; k++) begin
            w_ins_before[k] = w_ins_before[k-1] | w_ge[k-1];
            w_rm_before[k]  = w_rm_before[k-1] | w_hit[k-1];
        end
    end

    // earliest deadline left once every due cell is gone
    always_comb begin
        w_next_dl = '1;
        for (int k = NUM_TIMERS-1; k >= 0; k--) begin
            if (w_late[k]) w_next_dl = r_dl[r_ord[k]];
        end
    end

    assign o_stat.head_due  = (r_cnt != '0) && (w_head_dl <= r_word.time_value);
    assign o_stat.arm_ok    = !r_pend[r_word.timer_id] && (r_cnt < CNT_W'(NUM_TIMERS));
    assign o_stat.cancel_ok = r_pend[r_word.timer_id];
    assign o_stat.func      = r_word.func;
    assign o_head_id        = r_ord[0];
    assign o_earliest       = (r_cnt == '0) ? '1 : w_head_dl;
    assign o_next_dl        = w_next_dl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
        if (i_cmd.do_arm) begin
            r_dl[r_word.timer_id] <= r_word.time_value;
        end
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if (i_cmd.do_arm) begin
                if (k == 0) begin
                    if (w_ge[0] || r_cnt == '0) r_ord[0] <= r_word.timer_id;
                end else if (w_ins_before[k] || w_ge[k]) begin
                    r_ord[k] <= (w_ge[k] && !w_ins_before[k]) ? r_word.timer_id
                                                              : r_ord[k-1];
                end else if (CNT_W'(k) == r_cnt) begin
                    r_ord[k] <= r_word.timer_id;
                end
            end else if (i_cmd.do_cancel) begin
                if (k < NUM_TIMERS-1 && (w_rm_before[k] || w_hit[k])) begin
                    r_ord[k] <= r_ord[k+1];
                end
            end else if (i_cmd.pop_head) begin
                if (k < NUM_TIMERS-1) r_ord[k] <= r_ord[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.do_arm) begin
            r_pend[r_word.timer_id] <= 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.do_cancel) begin
            r_pend[r_word.timer_id] <= 1'b0;
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.pop_head) begin
            r_pend[r_ord[0]] <= 1'b0;
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ hdl/stq_ctrl.sv @@
// Controller FSM of the sorted timer queue: sequences arm, cancel and the
// expire pop loop, drives the output register. Uses stq_pkg.
module stq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  stq_pkg::t_stat     i_stat,
    input  logic [3:0]         i_head_id,
    input  logic [63:0]        i_earliest,
    input  logic [63:0]        i_next_dl,
    output stq_pkg::t_cmd      o_cmd,
    output stq_pkg::t_out_word o_word
);
    import stq_pkg::*;

    t_state    r_state, n_state;
    logic      r_ov;
    t_out_word r_out;
    logic      r_pend_id_v;
    logic [ID_W-1:0] r_pend_id;
    logic [1:0] r_status;
    logic      w_out_free;
    logic      w_out_load;

    assign w_out_free  = !r_ov || i_out_ready;
    assign w_out_load  = w_out_free && ((r_state == S_EMIT) ||
                                        (r_state == S_EXP_SHIFT && r_pend_id_v));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_word      = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.func == FUNC_EXPIRE) n_state = S_EXP_CHECK;
                else n_state = S_EMIT;
            end
            S_EXP_CHECK: begin
                if (i_stat.head_due) n_state = S_EXP_SHIFT;
                else n_state = S_EMIT;
            end
            S_EXP_SHIFT: if (w_out_free) n_state = S_EXP_CHECK;
            S_EMIT:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_EXEC: begin
                o_cmd.do_arm    = (i_stat.func == FUNC_ARM) && i_stat.arm_ok;
                o_cmd.do_cancel = (i_stat.func == FUNC_CANCEL) && i_stat.cancel_ok;
            end
            S_EXP_SHIFT: o_cmd.pop_head = w_out_free;
            default: ;
        endcase
    end

    // Fired ids are held one step so that last can be known before a word
    // leaves: a popped id waits in r_pend_id.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_pend_id_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_EXEC: begin
                    r_pend_id_v <= 1'b0;
                    if (i_stat.func == FUNC_ARM)
                        r_status <= i_stat.arm_ok ? ST_OK : ST_MISUSE;
                    else if (i_stat.func == FUNC_CANCEL)
                        r_status <= i_stat.cancel_ok ? ST_OK : ST_MISUSE;
                    else if (i_stat.func == FUNC_EXPIRE)
                        r_status <= ST_NONE;
                    else
                        r_status <= ST_MISUSE;
                end
                S_EXP_SHIFT: begin
                    if (w_out_free) begin
                        if (r_pend_id_v) begin
                            r_out <= '{fired: 1'b1, expired_id: r_pend_id, status: ST_OK,
                                       next_deadline: i_next_dl, last: 1'b0};
                        end
                        r_pend_id   <= i_head_id;
                        r_pend_id_v <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (r_pend_id_v)
                            r_out <= '{fired: 1'b1, expired_id: r_pend_id, status: ST_OK,
                                       next_deadline: i_earliest, last: 1'b1};
                        else
                            r_out <= '{fired: 1'b0, expired_id: '0, status: r_status,
                                       next_deadline: i_earliest, last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/sorted_timer_queue.sv @@
// Sorted timer queue: holds up to sixteen timer slots in a chain of cells
// kept in deadline order. Arm and cancel each give one word. Expire runs
// the pop loop in the controller, moving one head entry per pass; each
// fired timer gives one word (one word with fired clear if none fires),
// the final one marked last, all carrying the earliest pending deadline
// after the step. A word not taken by the receiver stalls the loop until
// it leaves. Depends on stq_pkg, stq_ctrl, stq_datapath.
module sorted_timer_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stq_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [63:0]        i_cfg_data
);
    import stq_pkg::*;

    logic [63:0] r_prio;
    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [3:0]  w_head_id;
    logic [63:0] w_earliest;
    logic [63:0] w_next_dl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prio <= '0;
        else if (i_cfg_valid) r_prio <= i_cfg_data;
    end

    stq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(w_stat), .i_head_id(w_head_id), .i_earliest(w_earliest),
        .i_next_dl(w_next_dl),
        .o_cmd(w_cmd), .o_word(o_out_word)
    );

    stq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_word(i_in_word), .i_prio_threshold(r_prio), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_head_id(w_head_id), .o_earliest(w_earliest),
        .o_next_dl(w_next_dl)
    );

endmodule
